// File: hdl/aesbc_pkg.sv
// aesbc_pkg: shared types, constants and round functions of the aes block engine
// no dependencies; sbox tables are built by constant functions at elaboration
`timescale 1ns / 1ps

package aesbc_pkg;

    localparam int DEF_MAX_ROUNDS = 14;
    localparam int RC_W           = 4;
    localparam int IDX_W          = 4;
    localparam int BLK_W          = 128;
    localparam logic [RC_W-1:0] MIN_ROUNDS = 4'd10;

    typedef enum logic [1:0] {
        KIND_LOAD_ENC = 2'd0,
        KIND_LOAD_DEC = 2'd1,
        KIND_ENC      = 2'd2,
        KIND_DEC      = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_ctl;

    typedef logic [7:0] t_tab [256];

    // field multiply, elaboration only
    function automatic logic [7:0] f_gmul(input logic [7:0] a_in, input logic [7:0] b_in);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] p;
        a = a_in;
        b = b_in;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p = p ^ a;
            a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] f_ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        r    = 8'h01;
        base = x;
        for (int e = 0; e < 8; e++) begin
            // exponent 254: every bit set except bit 0
            if (e != 0) r = f_gmul(r, base);
            base = f_gmul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] f_rotl(input logic [7:0] b, input int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic t_tab f_make_sbox();
        t_tab t;
        logic [7:0] b;
        for (int i = 0; i < 256; i++) begin
            b = f_ginv(8'(i));
            t[i] = b ^ f_rotl(b, 1) ^ f_rotl(b, 2) ^ f_rotl(b, 3) ^ f_rotl(b, 4) ^ 8'h63;
        end
        return t;
    endfunction

    function automatic t_tab f_make_inv_sbox();
        t_tab t;
        logic [7:0] y;
        for (int i = 0; i < 256; i++) begin
            y = 8'(i);
            t[i] = f_ginv(f_rotl(y, 1) ^ f_rotl(y, 3) ^ f_rotl(y, 6) ^ 8'h05);
        end
        return t;
    endfunction

    localparam t_tab SBOX     = f_make_sbox();
    localparam t_tab INV_SBOX = f_make_inv_sbox();

    function automatic logic [7:0] f_xt(input logic [7:0] a);
        return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    endfunction

    // one encryption round without key add, byte 0 in the top bits
    function automatic logic [BLK_W-1:0] f_enc_round(input logic [BLK_W-1:0] st,
                                                     input logic mix);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [BLK_W-1:0] res;
        for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r+4*c] = SBOX[s[r+4*((c+r)&3)]];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (mix) begin
                t[4*c]   = f_xt(a0) ^ f_xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ f_xt(a1) ^ f_xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ f_xt(a2) ^ f_xt(a3) ^ a3;
                t[4*c+3] = f_xt(a0) ^ a0 ^ a1 ^ a2 ^ f_xt(a3);
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = t[i];
        return res;
    endfunction

    // one round of the equivalent inverse cipher without key add
    function automatic logic [BLK_W-1:0] f_dec_round(input logic [BLK_W-1:0] st,
                                                     input logic mix);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        logic [BLK_W-1:0] res;
        for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r+4*c] = INV_SBOX[s[r+4*((c-r+4)&3)]];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]   = t[4*c+k];
                x2     = f_xt(a[k]);
                x4     = f_xt(x2);
                x8     = f_xt(x4);
                m9[k]  = x8 ^ a[k];
                m11[k] = x8 ^ x2 ^ a[k];
                m13[k] = x8 ^ x4 ^ a[k];
                m14[k] = x8 ^ x4 ^ x2;
            end
            if (mix) begin
                t[4*c]   = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
                t[4*c+1] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
                t[4*c+2] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
                t[4*c+3] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = t[i];
        return res;
    endfunction

endpackage

// File: hdl/aesbc_stage.sv
// aesbc_stage: one pipeline slot of the aes engine with its two round keys
// depends on aesbc_pkg; stage 0 does the initial key add, others a round if active
`timescale 1ns / 1ps

module aesbc_stage #(
    parameter int STAGE = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [aesbc_pkg::RC_W-1:0] i_nr,
    input  logic                      i_vld,
    input  aesbc_pkg::t_ctl           i_ctl,
    input  logic [aesbc_pkg::BLK_W-1:0] i_data,
    input  logic                      i_nxt_rdy,
    output logic                      o_rdy,
    output logic                      o_vld,
    output aesbc_pkg::t_ctl           o_ctl,
    output logic [aesbc_pkg::BLK_W-1:0] o_data
);
    import aesbc_pkg::*;

    logic             r_vld;
    t_ctl             r_ctl;
    logic [BLK_W-1:0] r_data;
    logic [BLK_W-1:0] r_ek;
    logic [BLK_W-1:0] r_dk;
    logic [BLK_W-1:0] n_data;
    logic [BLK_W-1:0] rnd;
    logic [BLK_W-1:0] key;
    logic             mv;
    logic             is_blk;
    logic             is_dec;

    // slot is free or drains this cycle
    assign o_rdy  = !r_vld || i_nxt_rdy;
    assign mv     = i_vld && o_rdy;
    assign is_blk = (i_ctl.kind == KIND_ENC) || (i_ctl.kind == KIND_DEC);
    assign is_dec = (i_ctl.kind == KIND_DEC);
    assign key    = is_dec ? r_dk : r_ek;

    // round datapath, rounds past the active count pass through
    generate
        if (STAGE == 0) begin : g_init
            assign rnd = i_data ^ key;
        end else begin : g_round
            logic act;
            logic mix;
            assign act = (RC_W'(STAGE) <= i_nr);
            assign mix = (RC_W'(STAGE) < i_nr);
            assign rnd = act ? ((is_dec ? f_dec_round(i_data, mix)
                                        : f_enc_round(i_data, mix)) ^ key)
                             : i_data;
        end
    endgenerate

    // key loads travel untouched
    assign n_data = is_blk ? rnd : i_data;

    // slot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // slot payload and key writes as a key load passes this slot
    always_ff @(posedge i_clk) begin
        if (mv) begin
            r_ctl  <= i_ctl;
            r_data <= n_data;
            if (i_ctl.kind == KIND_LOAD_ENC && i_ctl.idx == IDX_W'(STAGE)) r_ek <= i_data;
            if (i_ctl.kind == KIND_LOAD_DEC && i_ctl.idx == IDX_W'(STAGE)) r_dk <= i_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_ctl  = r_ctl;
    assign o_data = r_data;

endmodule

// File: hdl/aes_block_cipher_enc_dec.sv
// aes_block_cipher_enc_dec: top level of the pipelined aes ecb engine
// depends on aesbc_pkg and aesbc_stage
`timescale 1ns / 1ps

// AES-128/192/256 block engine, fully unrolled: one slot for the initial key add
// and one slot per round up to MAX_ROUNDS, then an output register. A transaction
// (key load or block) is accepted every cycle unless the output stalls; a block
// result passes all slots and the output register at each round count, as rounds
// above the active count pass through. Each slot holds its own encryption and
// decryption round key; a key load walks the pipeline and writes its key when it
// reaches the slot of its round index, so it takes effect exactly for the blocks
// behind it. Unloaded keys read as undefined. Decryption keys are for the
// equivalent inverse cipher. Write round count only while idle; not enforced here.
module aes_block_cipher_enc_dec #(
    parameter int MAX_ROUNDS = aesbc_pkg::DEF_MAX_ROUNDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config: round_count
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_data,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,  // round_index[3:0], block_hi[67:4], block_lo[131:68]
    input  logic [1:0]   i_s_tuser,  // kind[1:0]
    input  logic         i_s_tlast,  // last_block
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,  // result_hi[63:0], result_lo[127:64]
    output logic         o_m_tlast   // out_last
);
    import aesbc_pkg::*;

    localparam int NS = MAX_ROUNDS + 1;

    logic [RC_W-1:0]  r_nr;
    logic [RC_W-1:0]  n_nr;
    logic             vld [NS+1];
    t_ctl             ctl [NS+1];
    logic [BLK_W-1:0] dat [NS+1];
    logic             rdy [NS+1];
    logic             r_o_vld;
    t_ctl             r_o_ctl;
    logic [BLK_W-1:0] r_o_data;
    logic             out_rdy;
    logic             last_blk;

    // active round count: clamp and round down to even
    always_comb begin
        n_nr = i_cfg_data;
        if (n_nr < MIN_ROUNDS) n_nr = MIN_ROUNDS;
        if (n_nr > RC_W'(MAX_ROUNDS)) n_nr = RC_W'(MAX_ROUNDS);
        n_nr = n_nr & ~RC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nr <= MIN_ROUNDS;
        end else if (i_cfg_valid) begin
            r_nr <= n_nr;
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline entry
    assign vld[0]      = i_s_tvalid;
    assign ctl[0].kind = t_kind'(i_s_tuser);
    assign ctl[0].idx  = i_s_tdata[3:0];
    assign ctl[0].last = i_s_tlast;
    assign dat[0]      = {i_s_tdata[67:4], i_s_tdata[131:68]};
    assign o_s_tready  = rdy[0];

    // round slots
    generate
        for (genvar s = 0; s < NS; s++) begin : g_stage
            aesbc_stage #(.STAGE(s)) u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_nr      (r_nr),
                .i_vld     (vld[s]),
                .i_ctl     (ctl[s]),
                .i_data    (dat[s]),
                .i_nxt_rdy (rdy[s+1]),
                .o_rdy     (rdy[s]),
                .o_vld     (vld[s+1]),
                .o_ctl     (ctl[s+1]),
                .o_data    (dat[s+1])
            );
        end
    endgenerate

    // output register, key loads drop out here
    assign out_rdy  = !r_o_vld || i_m_tready;
    assign rdy[NS]  = out_rdy;
    assign last_blk = (ctl[NS].kind == KIND_ENC) || (ctl[NS].kind == KIND_DEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_rdy) begin
            r_o_vld <= vld[NS] && last_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && vld[NS]) begin
            r_o_ctl  <= ctl[NS];
            r_o_data <= dat[NS];
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {r_o_data[63:0], r_o_data[127:64]};
    assign o_m_tlast  = r_o_ctl.last;

endmodule

// File: dv/aes_block_cipher_enc_dec_test.sv
// aes_block_cipher_enc_dec_test: self-checking bench for the pipelined aes ecb engine
// depends on aesbc_pkg for the item kinds; uses its own cipher model for expected blocks
`timescale 1ns / 1ps

module aes_block_cipher_enc_dec_test;
    import aesbc_pkg::*;

    localparam int KEY_SLOTS   = 15;
    localparam int PIPE_DRAIN  = 40;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [127:0] blk;
        logic         last;
    } t_cipher_out;

    typedef struct {
        t_kind        kind;
        logic [3:0]   idx;
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic         last;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [3:0]   i_cfg_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [135:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         i_s_tlast = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [127:0] o_m_tdata;
    logic         o_m_tlast;

    // model state
    logic [7:0]   sub_tab [256];
    logic [7:0]   inv_tab [256];
    logic [63:0]  key_mem [4*KEY_SLOTS];
    logic [3:0]   rounds_reg;
    t_cipher_out  pending_blocks [$];

    int  mismatch_cnt = 0;
    int  burst_left = 0;
    bit  stream_on = 0;
    bit  hold_req = 0;
    t_dir_row dir_rows [24];

    aes_block_cipher_enc_dec dut (.*);

    always #2 i_clk = ~i_clk;

    // field arithmetic for the model
    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
        end
        return p;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] b, input int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic logic [7:0] finv(input logic [7:0] x);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 0; i < 254; i++) r = fmul(r, x);
        return r;
    endfunction

    function automatic logic [127:0] enc_rnd(input logic [127:0] st, input logic mix);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [127:0] res;
        for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[r+4*c] = sub_tab[s[r+4*((c+r)&3)]];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = t[4*c+k];
            if (mix) begin
                t[4*c]   = fmul(a[0], 2) ^ fmul(a[1], 3) ^ a[2] ^ a[3];
                t[4*c+1] = a[0] ^ fmul(a[1], 2) ^ fmul(a[2], 3) ^ a[3];
                t[4*c+2] = a[0] ^ a[1] ^ fmul(a[2], 2) ^ fmul(a[3], 3);
                t[4*c+3] = fmul(a[0], 3) ^ a[1] ^ a[2] ^ fmul(a[3], 2);
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = t[i];
        return res;
    endfunction

    function automatic logic [127:0] dec_rnd(input logic [127:0] st, input logic mix);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [127:0] res;
        for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[r+4*c] = inv_tab[s[r+4*((c-r+4)&3)]];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = t[4*c+k];
            if (mix) begin
                t[4*c]   = fmul(a[0], 14) ^ fmul(a[1], 11) ^ fmul(a[2], 13) ^ fmul(a[3], 9);
                t[4*c+1] = fmul(a[0], 9) ^ fmul(a[1], 14) ^ fmul(a[2], 11) ^ fmul(a[3], 13);
                t[4*c+2] = fmul(a[0], 13) ^ fmul(a[1], 9) ^ fmul(a[2], 14) ^ fmul(a[3], 11);
                t[4*c+3] = fmul(a[0], 11) ^ fmul(a[1], 13) ^ fmul(a[2], 9) ^ fmul(a[3], 14);
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = t[i];
        return res;
    endfunction

    // apply one accepted item to the model state
    task automatic cipher_model(input t_kind k, input logic [3:0] idx,
                                input logic [63:0] hi, input logic [63:0] lo,
                                input logic last);
        int base, nr;
        logic [127:0] st;
        t_cipher_out o;
        if (k == KIND_LOAD_ENC || k == KIND_LOAD_DEC) begin
            if (idx <= 14) begin
                base = 2 * ((k == KIND_LOAD_DEC ? KEY_SLOTS : 0) + idx);
                key_mem[base]   = hi;
                key_mem[base+1] = lo;
            end
        end else begin
            nr = rounds_reg;
            if (nr < 10) nr = 10;
            if (nr > 14) nr = 14;
            nr = nr & ~1;
            base = (k == KIND_DEC) ? 2 * KEY_SLOTS : 0;
            st = {hi, lo} ^ {key_mem[base], key_mem[base+1]};
            for (int r = 1; r <= nr; r++) begin
                st = (k == KIND_ENC) ? enc_rnd(st, r < nr) : dec_rnd(st, r < nr);
                st ^= {key_mem[base+2*r], key_mem[base+2*r+1]};
            end
            o.blk  = st;
            o.last = last;
            pending_blocks.push_back(o);
        end
    endtask

    // offer one item, bursts of random length with random gaps
    task automatic push_item(input t_kind k, input logic [3:0] idx,
                             input logic [63:0] hi, input logic [63:0] lo,
                             input logic last);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, lo, hi, idx};
        i_s_tuser  <= k;
        i_s_tlast  <= last;
        stream_on = 1;
        do @(posedge i_clk); while (!o_s_tready);
        cipher_model(k, idx, hi, lo, last);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            stream_on = 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
        end
    endtask

    // write the round count while the engine is idle
    task automatic set_rounds(input logic [3:0] v);
        if (stream_on) begin
            i_s_tvalid <= 1'b0;
            stream_on = 0;
        end
        @(posedge i_clk);
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        rounds_reg = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [63:0] hi, lo;
        t_kind k;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: k = KIND_LOAD_ENC;
            1: k = KIND_LOAD_DEC;
            2, 3, 4, 5: k = KIND_ENC;
            default: k = KIND_DEC;
        endcase
        push_item(k, 4'($urandom_range(0, 15)), hi, lo, 1'($urandom));
    endtask

    // result checker with its own stall pattern and one long hold-off
    initial begin
        t_cipher_out e;
        int mode, mode_left, hold_left;
        mode = 0; mode_left = 0; hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_blocks.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %h last %b", o_m_tdata, o_m_tlast);
                end else begin
                    e = pending_blocks.pop_front();
                    if (o_m_tdata[63:0] !== e.blk[127:64] || o_m_tdata[127:64] !== e.blk[63:0]
                        || o_m_tlast !== e.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp hi %h lo %h last %b, got hi %h lo %h last %b",
                                     e.blk[127:64], e.blk[63:0], e.last,
                                     o_m_tdata[63:0], o_m_tdata[127:64], o_m_tlast);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!i_rst_n) begin
                i_m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom);
                    default: i_m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        logic [3:0] phase_rounds [8];
        for (int i = 0; i < 256; i++) begin
            sub_tab[i] = 8'h00;
        end
        for (int i = 0; i < 256; i++) begin
            logic [7:0] b;
            b = finv(8'(i));
            sub_tab[i] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
        end
        for (int i = 0; i < 256; i++) inv_tab[sub_tab[i]] = 8'(i);
        for (int i = 0; i < 4*KEY_SLOTS; i++) key_mem[i] = '0;
        rounds_reg = 4'd10;
        phase_rounds = '{4'd14, 4'd12, 4'd11, 4'd13, 4'd0, 4'd15, 4'd9, 4'd10};

        dir_rows[0]  = '{KIND_ENC, 4'd0, 64'h0, 64'h0, 1'b0};
        dir_rows[1]  = '{KIND_ENC, 4'd15, '1, '1, 1'b1};
        dir_rows[2]  = '{KIND_DEC, 4'd0, 64'h0, 64'h0, 1'b1};
        dir_rows[3]  = '{KIND_DEC, 4'd15, '1, '1, 1'b0};
        dir_rows[4]  = '{KIND_ENC, 4'd5, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0};
        dir_rows[5]  = '{KIND_DEC, 4'd9, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1};
        // round index past the key store is dropped
        dir_rows[6]  = '{KIND_LOAD_ENC, 4'd15, '1, '1, 1'b1};
        dir_rows[7]  = '{KIND_ENC, 4'd0, 64'h0, 64'h0, 1'b0};
        dir_rows[8]  = '{KIND_LOAD_DEC, 4'd15, '1, '1, 1'b0};
        dir_rows[9]  = '{KIND_DEC, 4'd0, '1, 64'h0, 1'b0};
        // extreme keys at both ends of each key set
        dir_rows[10] = '{KIND_LOAD_ENC, 4'd0, 64'h0, 64'h0, 1'b0};
        dir_rows[11] = '{KIND_LOAD_ENC, 4'd10, '1, '1, 1'b1};
        dir_rows[12] = '{KIND_ENC, 4'd0, 64'h0, '1, 1'b1};
        dir_rows[13] = '{KIND_LOAD_DEC, 4'd0, '1, '1, 1'b0};
        dir_rows[14] = '{KIND_LOAD_DEC, 4'd10, 64'h0, 64'h0, 1'b1};
        dir_rows[15] = '{KIND_DEC, 4'd0, 64'h0, '1, 1'b0};
        // keys above the active round count are stored but unused
        dir_rows[16] = '{KIND_LOAD_ENC, 4'd14, '1, 64'h0, 1'b0};
        dir_rows[17] = '{KIND_LOAD_DEC, 4'd14, 64'h0, '1, 1'b0};
        dir_rows[18] = '{KIND_ENC, 4'd3, 64'h8000000000000001, 64'h8000000000000001, 1'b1};
        dir_rows[19] = '{KIND_DEC, 4'd3, 64'h8000000000000001, 64'h8000000000000001, 1'b1};
        dir_rows[20] = '{KIND_ENC, 4'd7, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0};
        dir_rows[21] = '{KIND_DEC, 4'd7, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0};
        dir_rows[22] = '{KIND_ENC, 4'd0, '1, '1, 1'b0};
        dir_rows[23] = '{KIND_DEC, 4'd0, '1, '1, 1'b1};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 20);

        // every round key written before any block reads it
        for (int i = 0; i < 2*KEY_SLOTS; i++)
            push_item(i < KEY_SLOTS ? KIND_LOAD_ENC : KIND_LOAD_DEC, 4'(i % KEY_SLOTS),
                      {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));

        foreach (dir_rows[i])
            push_item(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].hi,
                      dir_rows[i].lo, dir_rows[i].last);
        for (int i = 0; i < 60; i++) random_item();

        foreach (phase_rounds[p]) begin
            set_rounds(phase_rounds[p]);
            for (int i = 0; i < 150; i++) begin
                if (p == 1 && i == 20) hold_req = 1;
                random_item();
            end
        end

        if (stream_on) i_s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
